// ===== design/multilevel_priority_task_scheduler_core_macros.svh =====
// assertion macros shared by the scheduler rtl
`ifndef MULTILEVEL_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// check a property on every clock, held off while reset is high
`define MPTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock, reset included
`define MPTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPTS_ASSERT(label, clk, rst, prop, msg)
`define MPTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/mpts_pkg.sv =====
`default_nettype none

package mpts_pkg;

  // field widths
  localparam int TASK_W     = 8;
  localparam int LEVEL_W    = 4;
  localparam int OPC_W      = 2;
  localparam int STAT_W     = 2;
  localparam int NLVL_W     = 3;
  localparam int CNT_W      = 32;
  localparam int POL_W      = 2;
  localparam int QUANT_W    = 8;
  localparam int QUANT_MAX  = 255;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OPC_W-1:0] OP_TICK = 2'd1;
  localparam logic [OPC_W-1:0] OP_SEL  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // policies
  localparam logic [POL_W-1:0] POL_RR   = 2'd0;
  localparam logic [POL_W-1:0] POL_MLFQ = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'd1;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

  // one queue operation per cycle, at one level
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [LEVEL_W-1:0] level;
    logic [TASK_W-1:0]  data;
  } queue_cmd_t;

endpackage

`default_nettype wire

// ===== design/mpts_req_if.sv =====
`default_nettype none

interface mpts_req_if;
  import mpts_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [TASK_W-1:0]  task_id;
  logic [LEVEL_W-1:0] task_level;

  modport source (output valid, output opcode, output task_id, output task_level,
                  input ready);
  modport sink (input valid, input opcode, input task_id, input task_level,
                output ready);
endinterface

`default_nettype wire

// ===== design/mpts_rsp_if.sv =====
`default_nettype none

interface mpts_rsp_if;
  import mpts_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              next_valid;
  logic [TASK_W-1:0] next_task;
  logic [NLVL_W-1:0] next_level;
  logic              switched;
  logic              preempted;
  logic              demoted;
  logic [CNT_W-1:0]  ctx_switches;
  logic [CNT_W-1:0]  preemptions;
  logic [CNT_W-1:0]  idle_selects;
  logic [CNT_W-1:0]  active_selects;
  logic [CNT_W-1:0]  tick_count;

  modport source (output valid, output status, output next_valid, output next_task,
                  output next_level, output switched, output preempted, output demoted,
                  output ctx_switches, output preemptions, output idle_selects,
                  output active_selects, output tick_count, input ready);
  modport sink (input valid, input status, input next_valid, input next_task,
                input next_level, input switched, input preempted, input demoted,
                input ctx_switches, input preemptions, input idle_selects,
                input active_selects, input tick_count, output ready);
endinterface

`default_nettype wire

// ===== design/multilevel_priority_task_scheduler_core.sv =====
// Sequence, accept to result valid: an enqueue, a non-expiring tick or an unused opcode goes
// through exec to done; a select or expiring tick goes on to scan, and to pop when a level is popped.
// A new item is taken only in idle, after the last result is loaded; the sequencer writes the queue
// memory in exec and pops the head in scan, with a registered read that is used in pop.
// Reset (rst, synchronous): clears pointers, counts, current task, counters; policy
// multilevel, quantum 10. The queue memory is not cleared and needs no clearing pass.
`default_nettype none

`include "multilevel_priority_task_scheduler_core_macros.svh"

module multilevel_priority_task_scheduler_core #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpts_pkg::CFG_DATA_W-1:0] cfg_data,
  mpts_req_if.sink                        req,
  mpts_rsp_if.source                      rsp
);
  import mpts_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam int SW = $clog2(QUANT_MAX * LEVELS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state;
  logic [POL_W-1:0]   policy;
  logic [QUANT_W-1:0] base_quantum;
  logic               rsp_valid;

  // latched item
  logic [OPC_W-1:0]   op_r;
  logic [TASK_W-1:0]  id_r;
  logic [LEVEL_W-1:0] lvl_r;

  // current task
  logic               cur_valid;
  logic [TASK_W-1:0]  cur_task;
  logic [LW-1:0]      cur_level;
  logic [SW-1:0]      cur_slice;

  // statistics
  logic [CNT_W-1:0] ctx_cnt;
  logic [CNT_W-1:0] pre_cnt;
  logic [CNT_W-1:0] idle_cnt;
  logic [CNT_W-1:0] act_cnt;
  logic [CNT_W-1:0] tick_cnt;

  // result being built
  logic [STAT_W-1:0]  res_status;
  logic               res_nv;
  logic [TASK_W-1:0]  res_nt;
  logic [LW-1:0]      res_nl;
  logic               res_sw;
  logic               res_pre;
  logic               res_dem;
  logic [LW-1:0]      pop_lvl;
  logic [LEVEL_W-1:0] nl_ext;

  // queue side
  queue_cmd_t        q_cmd;
  logic              q_full;
  logic [LEVELS-1:0] q_nonempty;
  logic [TASK_W-1:0] q_rd;

  logic               bad_level;
  logic [SW-1:0]      slice_dec;
  logic               expire;
  logic               found;
  logic [LW-1:0]      found_lvl;
  logic [LW-1:0]      mul_lvl;
  logic [LW:0]        factor;
  logic [SW-1:0]      new_slice;

  mpts_queues #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_cmd),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rd_data  (q_rd)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;

  // enqueue level check and slice countdown
  assign bad_level = ({1'b0, lvl_r} >= (LEVEL_W + 1)'(LEVELS));
  assign slice_dec = (cur_slice == '0) ? '0 : cur_slice - SW'(1);
  assign expire    = (slice_dec == '0);

  // lowest-numbered non-empty level
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (q_nonempty[l]) begin
        found     = 1'b1;
        found_lvl = LW'(l);
      end
    end
  end

  // slice of a level: quantum times (levels minus level)
  assign mul_lvl   = (state == S_POP) ? pop_lvl : cur_level;
  assign factor    = (LW + 1)'(LEVELS) - (LW + 1)'(mul_lvl);
  assign new_slice = SW'(base_quantum) * SW'(factor);

  // queue command for the current step
  always_comb begin
    q_cmd       = '0;
    q_cmd.data  = cur_task;
    q_cmd.level = LEVEL_W'(cur_level);
    unique case (state)
      S_EXEC: begin
        if (op_r == OP_ENQ) begin
          q_cmd.level = lvl_r;
          q_cmd.data  = id_r;
          q_cmd.push  = !bad_level && !q_full;
        end else if (op_r == OP_TICK) begin
          q_cmd.push = cur_valid && expire && !q_full;
        end
      end
      S_SCAN: begin
        q_cmd.level = LEVEL_W'(found_lvl);
        q_cmd.pop   = (policy != POL_RR) && found;
      end
      default: begin
      end
    endcase
  end

  // sequencer, current task and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      policy       <= POL_MLFQ;
      base_quantum <= QUANTUM_RESET;
      rsp_valid    <= 1'b0;
      cur_valid    <= 1'b0;
      cur_task     <= '0;
      cur_level    <= '0;
      cur_slice    <= '0;
      ctx_cnt      <= '0;
      pre_cnt      <= '0;
      idle_cnt     <= '0;
      act_cnt      <= '0;
      tick_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POLICY:  policy       <= cfg_data[POL_W-1:0];
          REG_QUANTUM: base_quantum <= cfg_data[QUANT_W-1:0];
        endcase
      end
      // result register load and transfer
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_r == OP_TICK) begin
            tick_cnt <= tick_cnt + CNT_W'(1);
            if (cur_valid && expire) begin
              pre_cnt   <= pre_cnt + CNT_W'(1);
              cur_slice <= new_slice;
              state     <= S_SCAN;
            end else begin
              if (cur_valid) begin
                cur_slice <= slice_dec;
              end
              state <= S_DONE;
            end
          end else if (op_r == OP_SEL) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (policy == POL_RR) begin
            state <= S_DONE;
            if (cur_valid) begin
              ctx_cnt <= ctx_cnt + CNT_W'(1);
              act_cnt <= act_cnt + CNT_W'(1);
            end else begin
              idle_cnt <= idle_cnt + CNT_W'(1);
            end
          end else if (found) begin
            state <= S_POP;
          end else begin
            state    <= S_DONE;
            idle_cnt <= idle_cnt + CNT_W'(1);
          end
        end
        S_POP: begin
          if (policy == POL_MLFQ) begin
            ctx_cnt <= ctx_cnt + CNT_W'(1);
          end
          act_cnt   <= act_cnt + CNT_W'(1);
          cur_valid <= 1'b1;
          cur_task  <= q_rd;
          cur_level <= pop_lvl;
          cur_slice <= new_slice;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item latch and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_r  <= req.opcode;
          id_r  <= req.task_id;
          lvl_r <= req.task_level;
        end
      end
      S_EXEC: begin
        res_status <= ST_OK;
        res_nv     <= 1'b0;
        res_nt     <= '0;
        res_nl     <= '0;
        res_sw     <= 1'b0;
        res_pre    <= 1'b0;
        res_dem    <= 1'b0;
        if (op_r == OP_ENQ) begin
          if (bad_level) begin
            res_status <= ST_BAD_LEVEL;
          end else if (q_full) begin
            res_status <= ST_FULL;
          end
        end else if (op_r == OP_TICK && cur_valid && expire) begin
          res_pre <= 1'b1;
          if (q_full) begin
            res_status <= ST_FULL;
          end
        end
      end
      S_SCAN: begin
        pop_lvl <= found_lvl;
        if (policy == POL_RR && cur_valid) begin
          res_nv <= 1'b1;
          res_nt <= cur_task;
          res_nl <= cur_level;
        end
      end
      S_POP: begin
        res_nv  <= 1'b1;
        res_nt  <= q_rd;
        res_nl  <= pop_lvl;
        res_sw  <= !cur_valid || (cur_task != q_rd);
        res_dem <= (policy == POL_MLFQ) && cur_valid && (cur_slice == '0) &&
                   (cur_level < LW'(LEVELS - 1));
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp.status         <= res_status;
          rsp.next_valid     <= res_nv;
          rsp.next_task      <= res_nt;
          rsp.next_level     <= nl_ext[NLVL_W-1:0];
          rsp.switched       <= res_sw;
          rsp.preempted      <= res_pre;
          rsp.demoted        <= res_dem;
          rsp.ctx_switches   <= ctx_cnt;
          rsp.preemptions    <= pre_cnt;
          rsp.idle_selects   <= idle_cnt;
          rsp.active_selects <= act_cnt;
          rsp.tick_count     <= tick_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  assign nl_ext = LEVEL_W'(res_nl);

  `MPTS_ASSERT(a_accept_exec, clk, rst, req.valid && req.ready |=> state == S_EXEC, "accept lost")
  `MPTS_ASSERT(a_pop_after_scan, clk, rst, state == S_POP |-> $past(state) == S_SCAN, "bad pop")
  `MPTS_ASSERT(a_done_load, clk, rst, state == S_DONE && (!rsp_valid || rsp.ready) |=> rsp_valid && state == S_IDLE, "result not loaded")

endmodule

`default_nettype wire

// ===== design/mpts_queues.sv =====
`default_nettype none

`include "multilevel_priority_task_scheduler_core_macros.svh"

module mpts_queues #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mpts_pkg::queue_cmd_t       cmd,
  output logic                       full,
  output logic [LEVELS-1:0]          nonempty,
  output logic [mpts_pkg::TASK_W-1:0] rd_data
);
  import mpts_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

  logic [TASK_W-1:0] store [LEVELS*QUEUE_DEPTH];
  logic [PW-1:0]     head  [LEVELS];
  logic [PW-1:0]     tail  [LEVELS];
  logic [CW-1:0]     count [LEVELS];

  logic [LW-1:0] sel;
  logic [PW-1:0] head_sel;
  logic [PW-1:0] tail_sel;
  logic [CW-1:0] count_sel;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // pointers of the level being worked on
  assign sel       = cmd.level[LW-1:0];
  assign head_sel  = head[sel];
  assign tail_sel  = tail[sel];
  assign count_sel = count[sel];
  assign full      = (count_sel == CW'(QUEUE_DEPTH));
  assign waddr     = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(tail_sel);
  assign raddr     = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(head_sel);

  // occupancy flags for the priority search
  for (genvar l = 0; l < LEVELS; l++) begin : g_flag
    assign nonempty[l] = (count[l] != '0);
  end

  // head, tail and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
    end else if (cmd.push) begin
      tail[sel]  <= (tail_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + PW'(1);
      count[sel] <= count_sel + CW'(1);
    end else if (cmd.pop) begin
      head[sel]  <= (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PW'(1);
      count[sel] <= count_sel - CW'(1);
    end
  end

  // task id memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[waddr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_data <= store[raddr];
    end
  end

  `MPTS_ASSERT(a_one_op, clk, rst, !(cmd.push && cmd.pop), "push and pop in one cycle")
  `MPTS_ASSERT(a_push_room, clk, rst, cmd.push |-> !full, "push into a full level")
  `MPTS_ASSERT(a_pop_data, clk, rst, cmd.pop |-> nonempty[sel], "pop from an empty level")

endmodule

`default_nettype wire
